FILE: sv/olads_pkg.sv
`default_nettype none

package olads_pkg;

  // Default list depth
  localparam int CAPACITY_DEF = 16;

  // Cells examined per scan cycle (power of two)
  localparam int SCAN_GROUP = 8;
  localparam int SCAN_LOG   = 3;

  // Operation codes
  localparam logic [1:0] FUNC_APPEND = 2'd0;
  localparam logic [1:0] FUNC_SEARCH = 2'd1;
  localparam logic [1:0] FUNC_DELETE = 2'd2;

  // Result status codes
  localparam logic [1:0] STAT_DONE      = 2'd0;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
  localparam logic [1:0] STAT_FULL      = 2'd2;

  // Controls broadcast to every cell
  typedef struct packed {
    logic cmp;    // latch compare against key
    logic app;    // cell at tail index takes key
    logic shift;  // cells at or after pos take neighbor's data
  } cell_ctl_t;

endpackage

`default_nettype wire

FILE: sv/olads_cell.sv
`default_nettype none

module olads_cell #(
  parameter int CAPACITY = olads_pkg::CAPACITY_DEF,
  parameter int IDX      = 0
) (
  input  wire logic                               clk,
  input  wire olads_pkg::cell_ctl_t               ctl,
  input  wire logic signed [31:0]                 key,
  input  wire logic [$clog2(CAPACITY+1)-1:0]      count,
  input  wire logic [$clog2(CAPACITY)-1:0]        pos,
  input  wire logic signed [31:0]                 nbr,
  output logic signed [31:0]                      data,
  output logic                                    hit
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = $clog2(CAPACITY);
  localparam logic [CW-1:0] IDX_C = CW'(IDX);
  localparam logic [PW-1:0] IDX_P = PW'(IDX);

  logic occupied;

  assign occupied = (IDX_C < count);

  always_ff @(posedge clk) begin
    if (ctl.app && (IDX_C == count)) begin
      data <= key;
    end else if (ctl.shift && (IDX_P >= pos)) begin
      data <= nbr;
    end
    if (ctl.cmp) begin
      hit <= occupied && (data == key);
    end
  end

endmodule

`default_nettype wire

FILE: sv/ordered_list_append_delete_search.sv
`default_nettype none

// Channel   Signals                              Handshake
// --------  -----------------------------------  ------------------------------
// request   func, value                          taken when start && !busy
// result    status, found, position, length      valid for one cycle with done
//
// Append and the unused code answer straight from idle: the result shows the cycle after
// the request and busy stays low, so those requests can go back to back.
// Search latches the compare in every cell, then scans eight cells a cycle
// until the first hit or the end of the held entries. Delete with a hit adds
// the S_SHIFT state for the shift. Synchronous rst empties the list but leaves
// cell contents; the receiver cannot stall, busy is the only hold.

module ordered_list_append_delete_search #(
  parameter int CAPACITY = olads_pkg::CAPACITY_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [1:0]         func,
  input  wire logic signed [31:0] value,
  output logic                    done,
  output logic [1:0]              status,
  output logic                    found,
  output logic [3:0]              position,
  output logic [4:0]              length
);

  localparam int CW  = $clog2(CAPACITY + 1);
  localparam int PW  = $clog2(CAPACITY);
  localparam int G   = olads_pkg::SCAN_GROUP;
  localparam int NG  = (CAPACITY + G - 1) / G;
  localparam int GW  = (NG > 1) ? $clog2(NG) : 1;
  localparam int NGP = 1 << GW;          // groups padded to a power of two
  localparam int HW  = NGP * G;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT
  } state_t;

  state_t                 state;
  logic [CW-1:0]          count;
  logic [GW-1:0]          grp;
  logic [PW-1:0]          pos;
  logic                   is_del;

  logic                   accept;
  olads_pkg::cell_ctl_t   ctl;
  logic signed [31:0]     cell_data [CAPACITY];
  logic [HW-1:0]          hits;
  logic [NGP-1:0][G-1:0]  hit_grp;
  logic [G-1:0]           grp_bits;
  logic                   grp_any;
  logic [olads_pkg::SCAN_LOG-1:0] lo;
  logic [PW-1:0]          pos_next;
  logic                   scan_end;
  logic                   full;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;
  assign full   = (count >= CW'(CAPACITY));

  // Broadcast controls: compare and append happen at request accept
  always_comb begin
    ctl.cmp   = accept;
    ctl.app   = accept && (func == olads_pkg::FUNC_APPEND) && !full;
    ctl.shift = (state == S_SHIFT);
  end

  // Row of cells; each hands its entry toward the head on a delete shift
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [31:0] nbr;
    if (i == CAPACITY - 1) begin : g_tail
      assign nbr = cell_data[i];
    end else begin : g_mid
      assign nbr = cell_data[i+1];
    end
    olads_cell #(
      .CAPACITY (CAPACITY),
      .IDX      (i)
    ) u_cell (
      .clk   (clk),
      .ctl   (ctl),
      .key   (value),
      .count (count),
      .pos   (pos),
      .nbr   (nbr),
      .data  (cell_data[i]),
      .hit   (hits[i])
    );
  end

  // Pad hit vector out to whole groups
  for (genvar j = CAPACITY; j < HW; j++) begin : g_pad
    assign hits[j] = 1'b0;
  end

  assign hit_grp  = hits;
  assign grp_bits = hit_grp[grp];
  assign grp_any  = |grp_bits;

  // First hit inside the current group
  always_comb begin
    lo = '0;
    for (int k = G - 1; k >= 0; k--) begin
      if (grp_bits[k]) begin
        lo = olads_pkg::SCAN_LOG'(k);
      end
    end
  end

  assign pos_next = PW'({grp, lo});
  // No held entry lies past this group
  assign scan_end = ((int'(grp) + 1) * G >= int'(count));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            unique case (func)
              olads_pkg::FUNC_APPEND: begin
                done     <= 1'b1;
                found    <= 1'b0;
                position <= '0;
                if (full) begin
                  status <= olads_pkg::STAT_FULL;
                  length <= 5'(count);
                end else begin
                  status <= olads_pkg::STAT_DONE;
                  count  <= count + CW'(1);
                  length <= 5'(count + CW'(1));
                end
              end
              olads_pkg::FUNC_SEARCH, olads_pkg::FUNC_DELETE: begin
                is_del <= (func == olads_pkg::FUNC_DELETE);
                grp    <= '0;
                state  <= S_SCAN;
              end
              default: begin
                done     <= 1'b1;
                status   <= olads_pkg::STAT_DONE;
                found    <= 1'b0;
                position <= '0;
                length   <= 5'(count);
              end
            endcase
          end
        end
        S_SCAN: begin
          if (grp_any) begin
            pos <= pos_next;
            if (is_del) begin
              state <= S_SHIFT;
            end else begin
              done     <= 1'b1;
              status   <= olads_pkg::STAT_DONE;
              found    <= 1'b1;
              position <= 4'(pos_next);
              length   <= 5'(count);
              state    <= S_IDLE;
            end
          end else if (scan_end) begin
            done     <= 1'b1;
            status   <= olads_pkg::STAT_NOT_FOUND;
            found    <= 1'b0;
            position <= '0;
            length   <= 5'(count);
            state    <= S_IDLE;
          end else begin
            grp <= grp + GW'(1);
          end
        end
        S_SHIFT: begin
          // cells close the gap this cycle
          count    <= count - CW'(1);
          done     <= 1'b1;
          status   <= olads_pkg::STAT_DONE;
          found    <= 1'b1;
          position <= 4'(pos);
          length   <= 5'(count - CW'(1));
          state    <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
